@@ hw/rtl/pva_pkg.sv @@
// Package: shared types, constants and tables of the polar vector adder.
`default_nettype none
package pva_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int RADIUS_BITS   = 16;
  localparam int MAX_STAGES    = 24;
  localparam int NSTG = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;
  localparam int FRAC = 12;
  // coordinate and rotation-angle widths inside the datapath
  localparam int CW = 36;
  localparam int ZW = 34;

  localparam logic [15:0] RADIUS_MASK =
    (RADIUS_BITS >= 16) ? 16'hFFFF : 16'((1 << RADIUS_BITS) - 1);
  localparam logic [20:0] RADIUS_CAP =
    (RADIUS_BITS >= 16) ? 21'h1FFFF : 21'((1 << (RADIUS_BITS + 1)) - 1);

  localparam logic [31:0] HALF_TURN = 32'h8000_0000;
  localparam logic signed [ZW-1:0] QUARTER = ZW'(34'sh0_4000_0000);
  localparam logic signed [ZW-1:0] HALF_Z  = ZW'(34'sh0_8000_0000);
  // (1/K)^2 in Q32, K = CORDIC gain
  localparam logic [31:0] GAIN2_Q32 = 32'd1583795390;

  localparam logic [31:0] ATAN_TAB [MAX_STAGES] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  typedef struct packed {
    logic [15:0] start_radius;
    logic [15:0] start_bearing;
    logic [15:0] step_length;
    logic [15:0] step_heading;
  } pva_in_t;

  typedef struct packed {
    logic [16:0] result_radius;
    logic [15:0] result_bearing;
  } pva_out_t;

  // folded rotation operands for both vectors
  typedef struct packed {
    logic signed [CW-1:0] x1;
    logic signed [ZW-1:0] z1;
    logic signed [CW-1:0] x2;
    logic signed [ZW-1:0] z2;
  } pva_op_t;

endpackage
`default_nettype wire

@@ hw/rtl/pva_front.sv @@
// Front end: accept items, mask radii and fold bearings into the right half plane.
`default_nettype none
module pva_front import pva_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    item_valid,
  output logic         item_ready,
  input  wire pva_in_t item,
  output logic         op_valid,
  input  wire logic    op_ready,
  output pva_op_t      op
);

  logic    fv;
  pva_op_t fop;

  function automatic void fold(input logic [15:0] r, input logic [15:0] b,
                               output logic signed [CW-1:0] x,
                               output logic signed [ZW-1:0] z);
    logic signed [CW-1:0] xr;
    logic signed [ZW-1:0] zr;
    xr = signed'(CW'({r & RADIUS_MASK, {FRAC{1'b0}}}));
    zr = ZW'(signed'({b, 16'h0000}));
    if (zr > QUARTER || zr < -QUARTER) begin
      x = -xr;
      z = (zr > 0) ? zr - HALF_Z : zr + HALF_Z;
    end else begin
      x = xr;
      z = zr;
    end
  endfunction

  always_comb begin
    fold(item.start_radius, item.start_bearing, fop.x1, fop.z1);
    fold(item.step_length, item.step_heading, fop.x2, fop.z2);
  end

  assign item_ready = !fv || op_ready;
  assign op_valid   = fv;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (item_ready) begin
      fv <= item_valid;
    end
    if (item_ready && item_valid) begin
      op <= fop;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/pva_queue.sv @@
// Two-entry queue between the front end and the CORDIC back end.
`default_nettype none
module pva_queue import pva_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push_valid,
  output logic         push_ready,
  input  wire pva_op_t push_data,
  output logic         pop_valid,
  input  wire logic    pop_ready,
  output pva_op_t      pop_data
);

  pva_op_t    mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop)  rd_ptr <= !rd_ptr;
      count <= count + 2'(do_push) - 2'(do_pop);
    end
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/pva_back.sv @@
// Back end: rotation CORDICs, vector sum, vectoring CORDIC, gain removal and rounding.
`default_nettype none
module pva_back import pva_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    op_valid,
  output logic         op_ready,
  input  wire pva_op_t op,
  output logic         result_valid,
  input  wire logic    result_ready,
  output pva_out_t     result
);

  localparam int L = 2 * NSTG + 4;

  logic [L-1:0] vld;
  logic         adv;

  logic signed [CW-1:0] ax [NSTG];
  logic signed [CW-1:0] ay [NSTG];
  logic signed [ZW-1:0] az [NSTG];
  logic signed [CW-1:0] bx [NSTG];
  logic signed [CW-1:0] by [NSTG];
  logic signed [ZW-1:0] bz [NSTG];

  logic signed [CW-1:0] sx, sy;
  logic signed [CW-1:0] fx, fy;
  logic [31:0]          fz;

  logic signed [CW-1:0] vx [NSTG];
  logic signed [CW-1:0] vy [NSTG];
  logic [31:0]          vz [NSTG];

  logic [63:0] prod;
  logic [31:0] mz;
  logic [31:0] mag;

  logic [64:0] rsum;
  logic [20:0] rad;
  logic [20:0] rad_cap;
  logic [31:0] zr;

  // advance the whole pipeline unless the output register is stalled
  assign adv          = !vld[L-1] || result_ready;
  assign op_ready     = adv;
  assign result_valid = vld[L-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[L-2:0], op_valid};
    end
  end

  for (genvar i = 0; i < NSTG; i++) begin : g_rot
    logic signed [CW-1:0] pax, pay, pbx, pby;
    logic signed [ZW-1:0] paz, pbz;
    logic signed [ZW-1:0] at;
    assign at = signed'(ZW'(ATAN_TAB[i]));
    if (i == 0) begin : g_src0
      assign pax = op.x1;
      assign pay = '0;
      assign paz = op.z1;
      assign pbx = op.x2;
      assign pby = '0;
      assign pbz = op.z2;
    end else begin : g_srcn
      assign pax = ax[i-1];
      assign pay = ay[i-1];
      assign paz = az[i-1];
      assign pbx = bx[i-1];
      assign pby = by[i-1];
      assign pbz = bz[i-1];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        if (paz >= 0) begin
          ax[i] <= pax - (pay >>> i);
          ay[i] <= pay + (pax >>> i);
          az[i] <= paz - at;
        end else begin
          ax[i] <= pax + (pay >>> i);
          ay[i] <= pay - (pax >>> i);
          az[i] <= paz + at;
        end
        if (pbz >= 0) begin
          bx[i] <= pbx - (pby >>> i);
          by[i] <= pby + (pbx >>> i);
          bz[i] <= pbz - at;
        end else begin
          bx[i] <= pbx + (pby >>> i);
          by[i] <= pby - (pbx >>> i);
          bz[i] <= pbz + at;
        end
      end
    end
  end

  // sum, then fold the sum into the right half plane
  always_ff @(posedge clk) begin
    if (adv) begin
      sx <= ax[NSTG-1] + bx[NSTG-1];
      sy <= ay[NSTG-1] + by[NSTG-1];
      if (sx < 0) begin
        fx <= -sx;
        fy <= -sy;
        fz <= HALF_TURN;
      end else begin
        fx <= sx;
        fy <= sy;
        fz <= '0;
      end
    end
  end

  for (genvar i = 0; i < NSTG; i++) begin : g_vec
    logic signed [CW-1:0] px, py;
    logic [31:0]          pz;
    if (i == 0) begin : g_src0
      assign px = fx;
      assign py = fy;
      assign pz = fz;
    end else begin : g_srcn
      assign px = vx[i-1];
      assign py = vy[i-1];
      assign pz = vz[i-1];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        if (py >= 0) begin
          vx[i] <= px + (py >>> i);
          vy[i] <= py - (px >>> i);
          vz[i] <= pz + ATAN_TAB[i];
        end else begin
          vx[i] <= px - (py >>> i);
          vy[i] <= py + (px >>> i);
          vz[i] <= pz - ATAN_TAB[i];
        end
      end
    end
  end

  assign mag = (vx[NSTG-1] > 0) ? vx[NSTG-1][31:0] : 32'd0;

  always_comb begin
    rsum    = {1'b0, prod} + (65'd1 << (31 + FRAC));
    rad     = rsum[64:32+FRAC];
    rad_cap = (rad > RADIUS_CAP) ? RADIUS_CAP : rad;
    zr      = mz + 32'h0000_8000;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod <= 64'(mag) * 64'(GAIN2_Q32);
      mz   <= vz[NSTG-1];
      result.result_radius  <= rad_cap[16:0];
      result.result_bearing <= (rad_cap == 21'd0) ? 16'h0000 : zr[31:16];
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/polar_vector_add.sv @@
// Top level of the polar vector adder: front end, queue and CORDIC back end.
// polar_vector_add performs one dead-reckoning step per transaction: it turns
// a start position and a step, each given as a radius and a compass bearing
// (binary angle, 65536 = one turn, clockwise from north), into north/east
// components with rotation CORDICs, adds them, and turns the sum back into a
// rounded radius and bearing with a vectoring CORDIC and one gain multiply.
// A zero radius result reports bearing 0. The block accepts one transaction
// per clock cycle while the result is not stalled, and is fully pipelined. A
// transaction passes the front register, the queue, the two CORDIC pipelines
// of NSTG stages each, and the sum, fold, multiply and output registers. A
// stalled result holds the whole back end while the front end keeps filling
// the queue.
`default_nettype none
module polar_vector_add import pva_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    item_valid,
  output logic         item_ready,
  input  wire pva_in_t item,
  output logic         result_valid,
  input  wire logic    result_ready,
  output pva_out_t     result
);

  logic    f_valid, f_ready;
  pva_op_t f_op;
  logic    q_valid, q_ready;
  pva_op_t q_op;

  // classify: mask radii, fold bearings
  pva_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .op_valid   (f_valid),
    .op_ready   (f_ready),
    .op         (f_op)
  );

  // decouple front and back stalls
  pva_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_op),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_op)
  );

  // CORDIC datapath with output register
  pva_back u_back (
    .clk          (clk),
    .rst          (rst),
    .op_valid     (q_valid),
    .op_ready     (q_ready),
    .op           (q_op),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
`default_nettype wire
